// ----- rtl/point_square_boundary_distance_macros.svh -----
`ifndef POINT_SQUARE_BOUNDARY_DISTANCE_MACROS_SVH
`define POINT_SQUARE_BOUNDARY_DISTANCE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PSBD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point_square_boundary_distance: check failed");

// next-cycle implication, sampled on clk, off during reset
`define PSBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("point_square_boundary_distance: check failed");

`endif

// ----- rtl/psbd_pkg.sv -----
`timescale 1ns / 1ps

package psbd_pkg;

    localparam int COORD_W    = 32;
    localparam int EXT_W      = COORD_W + 2;
    localparam int DIST_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int ROOT_W     = COORD_W;
    localparam int ROOT_STEPS = ROOT_W;

    localparam logic [COORD_W-1:0] SIDE_RESET = 32'h0001_0000;

    typedef struct packed {
        logic              use_root;
        logic              outside;
        logic [DIST_W-1:0] value;
    } psbd_side_t;

endpackage

// ----- rtl/point_square_boundary_distance.sv -----
// channel   | valid / strobe   | payload                  | width
// request   | start (& !busy)  | point_x, point_y         | 32 s, 32 s
// result    | done             | distance, outside        | 33 u, 1
// config    | side_length_we   | side_length              | 32 s
//
// A request enters every cycle; busy stays low.
// A result passes through 4 setup stages (mirror, excess, square, sum),
// 32 root stages of one bit each and 1 output stage.
// Reset clears the valid bits and sets side_length to 1.0 (0x0001_0000).
// The receiver cannot stall; done is a one-cycle strobe.
`timescale 1ns / 1ps
`include "point_square_boundary_distance_macros.svh"

module point_square_boundary_distance
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [psbd_pkg::COORD_W-1:0]   point_x,
    input  logic signed [psbd_pkg::COORD_W-1:0]   point_y,
    input  logic                                  side_length_we,
    input  logic signed [psbd_pkg::COORD_W-1:0]   side_length,
    output logic                                  done,
    output logic        [psbd_pkg::DIST_W-1:0]    distance,
    output logic                                  outside
);

    logic        [psbd_pkg::COORD_W-1:0] side_length_reg;

    logic                                s1_valid_reg;
    logic signed [psbd_pkg::EXT_W-1:0]   s1_k_reg;
    logic signed [psbd_pkg::EXT_W-1:0]   s1_x_reg;
    logic signed [psbd_pkg::EXT_W-1:0]   s1_y_reg;
    logic signed [psbd_pkg::EXT_W-1:0]   s1_k_next;
    logic signed [psbd_pkg::EXT_W-1:0]   s1_x_next;
    logic signed [psbd_pkg::EXT_W-1:0]   s1_y_next;
    logic signed [psbd_pkg::EXT_W-1:0]   k_ext;
    logic signed [psbd_pkg::EXT_W-1:0]   x_ext;
    logic signed [psbd_pkg::EXT_W-1:0]   y_ext;

    logic                                s2_valid_reg;
    logic                                s2_inside_reg;
    logic                                s2_inside_next;
    logic        [psbd_pkg::COORD_W-1:0] s2_dx_reg;
    logic        [psbd_pkg::COORD_W-1:0] s2_dx_next;
    logic        [psbd_pkg::COORD_W-1:0] s2_dy_reg;
    logic        [psbd_pkg::COORD_W-1:0] s2_dy_next;
    logic signed [psbd_pkg::EXT_W-1:0]   s2_min_a_reg;
    logic signed [psbd_pkg::EXT_W-1:0]   s2_min_a_next;
    logic signed [psbd_pkg::EXT_W-1:0]   s2_min_b_reg;
    logic signed [psbd_pkg::EXT_W-1:0]   s2_min_b_next;
    logic signed [psbd_pkg::EXT_W-1:0]   dx_full;
    logic signed [psbd_pkg::EXT_W-1:0]   dy_full;
    logic signed [psbd_pkg::EXT_W-1:0]   kx;
    logic signed [psbd_pkg::EXT_W-1:0]   ky;

    logic                                s3_valid_reg;
    psbd_pkg::psbd_side_t                s3_side_reg;
    psbd_pkg::psbd_side_t                s3_side_next;
    logic        [psbd_pkg::SQ_W-1:0]    s3_sq_x_reg;
    logic        [psbd_pkg::SQ_W-1:0]    s3_sq_x_next;
    logic        [psbd_pkg::SQ_W-1:0]    s3_sq_y_reg;
    logic        [psbd_pkg::SQ_W-1:0]    s3_sq_y_next;
    logic signed [psbd_pkg::EXT_W-1:0]   min_ab;

    logic                                s4_valid_reg;
    psbd_pkg::psbd_side_t                s4_side_reg;
    logic        [psbd_pkg::SQ_W-1:0]    s4_sum_reg;
    logic        [psbd_pkg::SQ_W-1:0]    s4_sum_next;

    logic                                root_valid;
    logic        [psbd_pkg::ROOT_W-1:0]  root_value;
    psbd_pkg::psbd_side_t                root_side;

    logic                                done_reg;
    logic        [psbd_pkg::DIST_W-1:0]  distance_reg;
    logic        [psbd_pkg::DIST_W-1:0]  distance_next;
    logic                                outside_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_length_reg <= psbd_pkg::SIDE_RESET;
        end
        else if (side_length_we)
        begin
            side_length_reg <= side_length;
        end
    end

    // mirror through origin for a negative side
    always_comb
    begin
        k_ext = psbd_pkg::EXT_W'(signed'(side_length_reg));
        x_ext = psbd_pkg::EXT_W'(point_x);
        y_ext = psbd_pkg::EXT_W'(point_y);
        if (k_ext < 0)
        begin
            s1_k_next = -k_ext;
            s1_x_next = -x_ext;
            s1_y_next = -y_ext;
        end
        else
        begin
            s1_k_next = k_ext;
            s1_x_next = x_ext;
            s1_y_next = y_ext;
        end
    end

    // classify, take per-axis excess and the partial edge minima
    always_comb
    begin
        s2_inside_next = !s1_x_reg[psbd_pkg::EXT_W-1] && !s1_y_reg[psbd_pkg::EXT_W-1] &&
                         (s1_x_reg <= s1_k_reg) && (s1_y_reg <= s1_k_reg);
        if (s1_x_reg < 0)
            dx_full = -s1_x_reg;
        else if (s1_x_reg > s1_k_reg)
            dx_full = s1_x_reg - s1_k_reg;
        else
            dx_full = '0;
        if (s1_y_reg < 0)
            dy_full = -s1_y_reg;
        else if (s1_y_reg > s1_k_reg)
            dy_full = s1_y_reg - s1_k_reg;
        else
            dy_full = '0;
        s2_dx_next    = dx_full[psbd_pkg::COORD_W-1:0];
        s2_dy_next    = dy_full[psbd_pkg::COORD_W-1:0];
        kx            = s1_k_reg - s1_x_reg;
        ky            = s1_k_reg - s1_y_reg;
        s2_min_a_next = (s1_y_reg < s1_x_reg) ? s1_y_reg : s1_x_reg;
        s2_min_b_next = (ky < kx) ? ky : kx;
    end

    // square the excesses, settle the direct answer
    always_comb
    begin
        min_ab       = (s2_min_b_reg < s2_min_a_reg) ? s2_min_b_reg : s2_min_a_reg;
        s3_sq_x_next = psbd_pkg::SQ_W'(s2_dx_reg) * psbd_pkg::SQ_W'(s2_dx_reg);
        s3_sq_y_next = psbd_pkg::SQ_W'(s2_dy_reg) * psbd_pkg::SQ_W'(s2_dy_reg);
        s3_side_next.outside  = !s2_inside_reg;
        s3_side_next.use_root = !s2_inside_reg && (s2_dx_reg != '0) && (s2_dy_reg != '0);
        if (s2_inside_reg)
            s3_side_next.value = min_ab[psbd_pkg::DIST_W-1:0];
        else if (s2_dx_reg == '0)
            s3_side_next.value = {1'b0, s2_dy_reg};
        else
            s3_side_next.value = {1'b0, s2_dx_reg};
    end

    assign s4_sum_next = s3_sq_x_reg + s3_sq_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= root_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_k_reg      <= s1_k_next;
        s1_x_reg      <= s1_x_next;
        s1_y_reg      <= s1_y_next;
        s2_inside_reg <= s2_inside_next;
        s2_dx_reg     <= s2_dx_next;
        s2_dy_reg     <= s2_dy_next;
        s2_min_a_reg  <= s2_min_a_next;
        s2_min_b_reg  <= s2_min_b_next;
        s3_side_reg   <= s3_side_next;
        s3_sq_x_reg   <= s3_sq_x_next;
        s3_sq_y_reg   <= s3_sq_y_next;
        s4_side_reg   <= s3_side_reg;
        s4_sum_reg    <= s4_sum_next;
        distance_reg  <= distance_next;
        outside_reg   <= root_side.outside;
    end

    psbd_isqrt u_isqrt
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s4_valid_reg),
        .in_radicand (s4_sum_reg),
        .in_side     (s4_side_reg),
        .out_valid   (root_valid),
        .out_root    (root_value),
        .out_side    (root_side)
    );

    assign distance_next = root_side.use_root ? {1'b0, root_value} : root_side.value;

    assign done     = done_reg;
    assign distance = distance_reg;
    assign outside  = outside_reg;

    `PSBD_ASSERT_NEXT(a_stage_no_drop, s1_valid_reg, s2_valid_reg && s3_valid_reg == 1'b0 || s2_valid_reg)
    `PSBD_ASSERT_NOW(a_inside_bound, done && !outside, distance[psbd_pkg::DIST_W-1:psbd_pkg::DIST_W-2] == 2'b00)
    `PSBD_ASSERT_NOW(a_outside_nonzero, done && outside, distance != '0)

endmodule

// ----- rtl/psbd_isqrt.sv -----
`timescale 1ns / 1ps

module psbd_isqrt
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [psbd_pkg::SQ_W-1:0]          in_radicand,
    input  psbd_pkg::psbd_side_t               in_side,
    output logic                               out_valid,
    output logic [psbd_pkg::ROOT_W-1:0]        out_root,
    output psbd_pkg::psbd_side_t               out_side
);

    logic                         valid_pipe [0:psbd_pkg::ROOT_STEPS];
    logic [psbd_pkg::SQ_W-1:0]    n_pipe     [0:psbd_pkg::ROOT_STEPS];
    logic [psbd_pkg::SQ_W-1:0]    r_pipe     [0:psbd_pkg::ROOT_STEPS];
    psbd_pkg::psbd_side_t         side_pipe  [0:psbd_pkg::ROOT_STEPS];

    assign valid_pipe[0] = in_valid;
    assign n_pipe[0]     = in_radicand;
    assign r_pipe[0]     = '0;
    assign side_pipe[0]  = in_side;

    for (genvar i = 0; i < psbd_pkg::ROOT_STEPS; i++)
    begin : g_step
        localparam logic [psbd_pkg::SQ_W-1:0] STEP_BIT =
            psbd_pkg::SQ_W'(1) << (psbd_pkg::SQ_W - 2 - 2 * i);

        logic                      valid_reg;
        logic [psbd_pkg::SQ_W-1:0] n_reg;
        logic [psbd_pkg::SQ_W-1:0] n_next;
        logic [psbd_pkg::SQ_W-1:0] r_reg;
        logic [psbd_pkg::SQ_W-1:0] r_next;
        psbd_pkg::psbd_side_t      side_reg;
        logic [psbd_pkg::SQ_W-1:0] trial;
        logic                      take;

        always_comb
        begin
            trial  = r_pipe[i] + STEP_BIT;
            take   = (n_pipe[i] >= trial);
            n_next = take ? (n_pipe[i] - trial) : n_pipe[i];
            r_next = take ? ((r_pipe[i] >> 1) + STEP_BIT) : (r_pipe[i] >> 1);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                valid_reg <= valid_pipe[i];
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg    <= n_next;
            r_reg    <= r_next;
            side_reg <= side_pipe[i];
        end

        assign valid_pipe[i+1] = valid_reg;
        assign n_pipe[i+1]     = n_reg;
        assign r_pipe[i+1]     = r_reg;
        assign side_pipe[i+1]  = side_reg;
    end

    assign out_valid = valid_pipe[psbd_pkg::ROOT_STEPS];
    assign out_root  = r_pipe[psbd_pkg::ROOT_STEPS][psbd_pkg::ROOT_W-1:0];
    assign out_side  = side_pipe[psbd_pkg::ROOT_STEPS];

endmodule
